// ----- hdl/led_keyframe_animator_top_defines.svh -----
// Assertion macros shared by the keyframe animator modules.
`ifndef LED_KEYFRAME_ANIMATOR_TOP_DEFINES_SVH
`define LED_KEYFRAME_ANIMATOR_TOP_DEFINES_SVH

// Same-cycle implication check.
`define LKA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication check.
`define LKA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/lka_pkg.sv -----
// Package with keyframe layout, phase codes and controller/datapath interface types.
package lka_pkg;

   localparam int LINK_W = 4;

   localparam logic [1:0] PH_STATIC = 2'd0;
   localparam logic [1:0] PH_HOLD   = 2'd1;
   localparam logic [1:0] PH_ATTACK = 2'd2;

   typedef struct packed {
      logic [1:0]        phase;
      logic [7:0]        count;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        attack;
      logic [7:0]        hold;
      logic [LINK_W-1:0] link;
   } frame_type;

   typedef struct packed {
      logic load_req;
      logic stage_wr;
      logic sweep;
      logic rd_cur;
      logic get_cur;
      logic get_nx;
      logic div_step;
      logic mix_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic commit;
      logic sweep_done;
      logic cur_attack;
      logic div_last;
      logic mix_last;
      logic out_free;
      logic last_led;
   } status_type;

endpackage

// ----- hdl/lka_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lka_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lka_ctrl.sv -----
// Controller state machine sequencing writes, commits and per-LED tick work.
`include "led_keyframe_animator_top_defines.svh"

module lka_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  lka_pkg::status_type status,
   output lka_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_WR      = 4'd1;
   localparam logic [3:0] S_CP      = 4'd2;
   localparam logic [3:0] S_RD_CUR  = 4'd3;
   localparam logic [3:0] S_GET_CUR = 4'd4;
   localparam logic [3:0] S_GET_NX  = 4'd5;
   localparam logic [3:0] S_DIV     = 4'd6;
   localparam logic [3:0] S_MIX     = 4'd7;
   localparam logic [3:0] S_EMIT    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = req_mode ? S_WR : S_RD_CUR;
            end
         end
         S_WR: begin
            cmd.stage_wr = 1'b1;
            state_in     = status.commit ? S_CP : S_IDLE;
         end
         S_CP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_RD_CUR: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_GET_CUR;
         end
         S_GET_CUR: begin
            cmd.get_cur = 1'b1;
            state_in    = status.cur_attack ? S_GET_NX : S_EMIT;
         end
         S_GET_NX: begin
            cmd.get_nx = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            cmd.mix_step = 1'b1;
            if (status.mix_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last_led ? S_IDLE : S_RD_CUR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LKA_ASSERT_NEXT(a_write_path, clock, reset, req_valid && req_ready && req_mode, state_ff == S_WR)
   `LKA_ASSERT_NEXT(a_div_holds, clock, reset, state_ff == S_DIV && !status.div_last, state_ff == S_DIV)
   `LKA_ASSERT_NEXT(a_tick_ends, clock, reset, cmd.emit && status.last_led, state_ff == S_IDLE)

endmodule

// ----- hdl/lka_dp.sv -----
// Datapath: keyframe tables, slot pointers, divider, blender and result register.
`include "led_keyframe_animator_top_defines.svh"

module lka_dp #(
   parameter int LED_COUNT      = 4,
   parameter int FRAMES_PER_LED = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  lka_pkg::cmd_type    cmd,
   output lka_pkg::status_type status,
   input  logic [1:0]          req_led_select,
   input  logic [1:0]          req_frame_slot,
   input  logic [15:0]         req_color_565,
   input  logic [7:0]          req_attack_ticks,
   input  logic [7:0]          req_hold_ticks,
   input  logic                req_last_frame,
   input  logic                req_commit,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_led_index,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   output logic                rsp_last_of_tick
);

   localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int SLOT_W = (FRAMES_PER_LED > 1) ? $clog2(FRAMES_PER_LED) : 1;
   localparam int AW     = LED_W + SLOT_W;
   localparam int DEPTH  = 2 ** AW;
   localparam int FW     = $bits(lka_pkg::frame_type);

   // Captured request.
   logic [1:0]  led_sel_ff;
   logic [1:0]  slot_sel_ff;
   logic [15:0] color_ff;
   logic [7:0]  att_ff;
   logic [7:0]  hld_ff;
   logic        last_ff;
   logic        commit_ff;

   // Table storage and valid bits.
   logic [DEPTH-1:0]  stv_ff;
   logic [DEPTH-1:0]  lvv_ff;
   logic              stv_q_ff;
   logic              lvv_q_ff;
   logic              st_wr_en;
   logic [AW-1:0]     st_wr_addr;
   logic [FW-1:0]     st_wr_data;
   logic [AW-1:0]     st_rd_addr;
   logic [FW-1:0]     st_rd_data;
   logic              lv_wr_en;
   logic [AW-1:0]     lv_wr_addr;
   logic [FW-1:0]     lv_wr_data;
   logic [AW-1:0]     lv_rd_addr;
   logic [FW-1:0]     lv_rd_data;
   logic [AW:0]       sweep_ff;
   logic [AW-1:0]     sweep_prev;

   // Per-LED work registers.
   logic [SLOT_W-1:0]  cur_slot_ff [LED_COUNT];
   logic [LED_W-1:0]   led_ff;
   lka_pkg::frame_type frame_ff;
   lka_pkg::frame_type rd_frame;
   lka_pkg::frame_type st_frame;
   lka_pkg::frame_type new_frame;
   lka_pkg::frame_type upd_frame;
   logic [7:0]         nx_red_ff;
   logic [7:0]         nx_green_ff;
   logic [7:0]         nx_blue_ff;
   logic [AW-1:0]      cur_addr;
   logic [AW-1:0]      link_addr;

   // Divider and blender.
   logic [8:0] rem_ff;
   logic [8:0] rem_shift;
   logic [7:0] quo_ff;
   logic [2:0] div_cnt_ff;
   logic [8:0] weight;
   logic [1:0] mix_cnt_ff;
   logic [7:0] mix_ff [3];
   logic [7:0] own_c;
   logic [7:0] nx_c;
   logic signed [9:0]  diff;
   logic signed [19:0] prod;
   logic signed [19:0] blend_sum;

   // Result register.
   logic       rsp_valid_ff;
   logic [1:0] rsp_led_ff;
   logic [7:0] rsp_red_ff;
   logic [7:0] rsp_green_ff;
   logic [7:0] rsp_blue_ff;
   logic       rsp_last_ff;
   logic       out_free;
   logic       is_attack;
   logic       is_hold;
   logic [7:0] cnt_inc;
   logic       advance;

   // Expand the staged keyframe from the captured write item.
   always_comb begin
      new_frame        = '0;
      new_frame.phase  = (att_ff != 8'd0) ? lka_pkg::PH_ATTACK :
                         ((hld_ff != 8'd0) ? lka_pkg::PH_HOLD : lka_pkg::PH_STATIC);
      new_frame.count  = 8'd0;
      new_frame.red    = {color_ff[15:11], color_ff[15:13]};
      new_frame.green  = {color_ff[10:5], color_ff[10:9]};
      new_frame.blue   = {color_ff[4:0], color_ff[4:2]};
      new_frame.attack = att_ff;
      new_frame.hold   = hld_ff;
      if (last_ff || (int'(slot_sel_ff) + 1 >= FRAMES_PER_LED)) begin
         new_frame.link = '0;
      end else begin
         new_frame.link = lka_pkg::LINK_W'(slot_sel_ff) + lka_pkg::LINK_W'(1);
      end
   end

   assign st_wr_en   = cmd.stage_wr && (int'(led_sel_ff) < LED_COUNT)
                       && (int'(slot_sel_ff) < FRAMES_PER_LED);
   assign st_wr_addr = {LED_W'(led_sel_ff), SLOT_W'(slot_sel_ff)};
   assign st_wr_data = new_frame;
   assign st_rd_addr = sweep_ff[AW-1:0];
   assign sweep_prev = AW'(sweep_ff - (AW + 1)'(1));
   assign st_frame   = stv_q_ff ? lka_pkg::frame_type'(st_rd_data) : '0;
   assign rd_frame   = lvv_q_ff ? lka_pkg::frame_type'(lv_rd_data) : '0;

   // Live table addressing.
   assign cur_addr   = {led_ff, cur_slot_ff[led_ff]};
   assign link_addr  = {led_ff, rd_frame.link[SLOT_W-1:0]};
   assign lv_rd_addr = cmd.get_cur ? link_addr : cur_addr;
   assign lv_wr_en   = (cmd.sweep && (sweep_ff != '0)) || cmd.emit;
   assign lv_wr_addr = cmd.sweep ? sweep_prev : cur_addr;
   assign lv_wr_data = cmd.sweep ? st_frame : upd_frame;

   lka_ram #(
      .WIDTH (FW),
      .DEPTH (DEPTH)
   ) u_staged_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   lka_ram #(
      .WIDTH (FW),
      .DEPTH (DEPTH)
   ) u_live_ram (
      .clock   (clock),
      .wr_en   (lv_wr_en),
      .wr_addr (lv_wr_addr),
      .wr_data (lv_wr_data),
      .rd_addr (lv_rd_addr),
      .rd_data (lv_rd_data)
   );

   // Phase update of the current keyframe after one tick.
   always_comb begin
      is_attack = (frame_ff.phase == lka_pkg::PH_ATTACK);
      is_hold   = (frame_ff.phase == lka_pkg::PH_HOLD);
      cnt_inc   = frame_ff.count + 8'd1;
      advance   = 1'b0;
      upd_frame = frame_ff;
      if (is_attack) begin
         upd_frame.count = cnt_inc;
         if (cnt_inc >= frame_ff.attack) begin
            advance         = 1'b1;
            upd_frame.phase = (frame_ff.hold != 8'd0) ? lka_pkg::PH_HOLD : lka_pkg::PH_ATTACK;
         end
      end else if (is_hold) begin
         upd_frame.count = cnt_inc;
         if (cnt_inc >= frame_ff.hold) begin
            advance         = 1'b1;
            upd_frame.phase = (frame_ff.attack != 8'd0) ? lka_pkg::PH_ATTACK : lka_pkg::PH_HOLD;
         end
      end
      if (advance) begin
         upd_frame.count = 8'd0;
      end
   end

   // Divider step and blend weight.
   assign rem_shift = {rem_ff[7:0], 1'b0};
   assign weight    = (frame_ff.count >= frame_ff.attack) ? 9'd256 : {1'b0, quo_ff};

   // Blend one colour per cycle: (next*256 + (own-next)*w) >> 8.
   always_comb begin
      case (mix_cnt_ff)
         2'd0: begin
            own_c = frame_ff.red;
            nx_c  = nx_red_ff;
         end
         2'd1: begin
            own_c = frame_ff.green;
            nx_c  = nx_green_ff;
         end
         default: begin
            own_c = frame_ff.blue;
            nx_c  = nx_blue_ff;
         end
      endcase
      diff      = signed'({2'b00, own_c}) - signed'({2'b00, nx_c});
      prod      = 20'(diff * signed'({1'b0, weight}));
      blend_sum = signed'({4'd0, nx_c, 8'd0}) + prod;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Control registers: valid bits, counters, slot pointers, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         stv_ff       <= '0;
         lvv_ff       <= '0;
         sweep_ff     <= '0;
         led_ff       <= '0;
         div_cnt_ff   <= '0;
         mix_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            cur_slot_ff[i] <= '0;
         end
      end else begin
         if (st_wr_en) begin
            stv_ff[st_wr_addr] <= 1'b1;
         end
         if (cmd.sweep) begin
            if (sweep_ff != '0) begin
               lvv_ff[sweep_prev] <= 1'b1;
            end
            if (status.sweep_done) begin
               sweep_ff <= '0;
               for (int i = 0; i < LED_COUNT; i++) begin
                  cur_slot_ff[i] <= '0;
               end
            end else begin
               sweep_ff <= sweep_ff + (AW + 1)'(1);
            end
         end
         if (cmd.load_req) begin
            led_ff <= '0;
         end
         if (cmd.get_cur) begin
            div_cnt_ff <= '0;
            mix_cnt_ff <= '0;
         end
         if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 3'd1;
         end
         if (cmd.mix_step) begin
            mix_cnt_ff <= mix_cnt_ff + 2'd1;
         end
         if (cmd.emit) begin
            lvv_ff[cur_addr] <= 1'b1;
            led_ff           <= led_ff + LED_W'(1);
            if (advance) begin
               cur_slot_ff[led_ff] <= upd_frame.link[SLOT_W-1:0];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stv_q_ff <= stv_ff[st_rd_addr];
      lvv_q_ff <= lvv_ff[lv_rd_addr];
      if (cmd.load_req) begin
         led_sel_ff  <= req_led_select;
         slot_sel_ff <= req_frame_slot;
         color_ff    <= req_color_565;
         att_ff      <= req_attack_ticks;
         hld_ff      <= req_hold_ticks;
         last_ff     <= req_last_frame;
         commit_ff   <= req_commit;
      end
      if (cmd.get_cur) begin
         frame_ff <= rd_frame;
         rem_ff   <= {1'b0, rd_frame.count};
         quo_ff   <= '0;
      end
      if (cmd.get_nx) begin
         nx_red_ff   <= rd_frame.red;
         nx_green_ff <= rd_frame.green;
         nx_blue_ff  <= rd_frame.blue;
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, frame_ff.attack}) begin
            rem_ff <= rem_shift - {1'b0, frame_ff.attack};
            quo_ff <= {quo_ff[6:0], 1'b1};
         end else begin
            rem_ff <= rem_shift;
            quo_ff <= {quo_ff[6:0], 1'b0};
         end
      end
      if (cmd.mix_step) begin
         mix_ff[mix_cnt_ff] <= blend_sum[15:8];
      end
      if (cmd.emit) begin
         rsp_led_ff   <= 2'(led_ff);
         rsp_last_ff  <= (int'(led_ff) == LED_COUNT - 1);
         rsp_red_ff   <= is_attack ? mix_ff[0] : frame_ff.red;
         rsp_green_ff <= is_attack ? mix_ff[1] : frame_ff.green;
         rsp_blue_ff  <= is_attack ? mix_ff[2] : frame_ff.blue;
      end
   end

   // Status back to the controller.
   always_comb begin
      status            = '0;
      status.commit     = commit_ff;
      status.sweep_done = (sweep_ff == (AW + 1)'(DEPTH));
      status.cur_attack = (rd_frame.phase == lka_pkg::PH_ATTACK);
      status.div_last   = (div_cnt_ff == 3'd7);
      status.mix_last   = (mix_cnt_ff == 2'd2);
      status.out_free   = out_free;
      status.last_led   = (int'(led_ff) == LED_COUNT - 1);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_index    = rsp_led_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_last_of_tick = rsp_last_ff;

   `LKA_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, out_free)
   `LKA_ASSERT_NEXT(a_emit_loads, clock, reset, cmd.emit, rsp_valid_ff)

endmodule

// ----- hdl/led_keyframe_animator_top.sv -----
// Top level of the LED keyframe animator: controller plus datapath.
//
// Input channel (req_*): an item with req_mode 1 writes one staging keyframe;
// with req_commit also set, the staging table is then copied to the live table
// and every LED restarts at slot 0. An item with req_mode 0 is an animation
// tick and yields one result per LED on the rsp_* channel, in LED order, with
// rsp_last_of_tick set on the final one. A write yields no result.
// The commit copy moves one table entry per cycle through the table RAMs.
// In a tick, an LED in an attack frame gets one RAM read each for the frame
// and its successor, an 8-step bit-serial divider for the blend weight and
// one blended colour per cycle; an LED in a static or hold frame gets only
// the frame read.
// Reset clears both tables and all slot pointers at once; no clearing pass.
// A result waits in the output register while rsp_ready is low; the next LED
// is worked on meanwhile and stalls only when its own result is ready.
module led_keyframe_animator_top #(
   parameter int LED_COUNT      = 4,
   parameter int FRAMES_PER_LED = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [1:0]  req_led_select,
   input  logic [1:0]  req_frame_slot,
   input  logic [15:0] req_color_565,
   input  logic [7:0]  req_attack_ticks,
   input  logic [7:0]  req_hold_ticks,
   input  logic        req_last_frame,
   input  logic        req_commit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last_of_tick
);

   lka_pkg::cmd_type    cmd;
   lka_pkg::status_type status;

   // Sequencer.
   lka_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables and arithmetic.
   lka_dp #(
      .LED_COUNT      (LED_COUNT),
      .FRAMES_PER_LED (FRAMES_PER_LED)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_led_select   (req_led_select),
      .req_frame_slot   (req_frame_slot),
      .req_color_565    (req_color_565),
      .req_attack_ticks (req_attack_ticks),
      .req_hold_ticks   (req_hold_ticks),
      .req_last_frame   (req_last_frame),
      .req_commit       (req_commit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_index    (rsp_led_index),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

endmodule

// ----- tb/sv/led_keyframe_animator_checker.sv -----
// Checker for the LED keyframe animator: tracks keyframe tables and checks LED colors.
module led_keyframe_animator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [1:0]  req_led_select,
   input  logic [1:0]  req_frame_slot,
   input  logic [15:0] req_color_565,
   input  logic [7:0]  req_attack_ticks,
   input  logic [7:0]  req_hold_ticks,
   input  logic        req_last_frame,
   input  logic        req_commit,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_led_index,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic        rsp_last_of_tick,
   output int          fail_count,
   output int          pending_colors
);

   typedef struct packed {
      logic [1:0] led;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } led_color_type;

   lka_pkg::frame_type live_tab[4][4];
   lka_pkg::frame_type stage_tab[4][4];
   logic [1:0]         play_slot[4];
   led_color_type      color_queue[$];

   // Expand RGB565 and store one keyframe in the staging table.
   task automatic stage_keyframe(input logic [1:0] led, input logic [1:0] slot,
                                 input logic [15:0] c, input logic [7:0] att,
                                 input logic [7:0] hld, input logic last);
      lka_pkg::frame_type f;
      logic [31:0] r, g, b;
      r = ((c & 16'hF800) * 32'h21) >> 13;
      g = ((c & 16'h07E0) * 32'h41) >> 9;
      b = ((c & 16'h001F) * 32'h21) >> 2;
      f.phase  = (att != 0) ? lka_pkg::PH_ATTACK :
                 ((hld != 0) ? lka_pkg::PH_HOLD : lka_pkg::PH_STATIC);
      f.count  = '0;
      f.red    = r[7:0];
      f.green  = g[7:0];
      f.blue   = b[7:0];
      f.attack = att;
      f.hold   = hld;
      f.link   = (last || slot == 2'd3) ? '0 : lka_pkg::LINK_W'(slot + 1);
      stage_tab[led][slot] = f;
   endtask

   // Advance every LED by one tick and queue the four colors it shows.
   task automatic animate_tick();
      lka_pkg::frame_type f, nx;
      led_color_type o;
      logic [31:0] w;
      logic adv;
      for (int i = 0; i < 4; i++) begin
         f = live_tab[i][play_slot[i]];
         adv = 1'b0;
         if (f.phase == lka_pkg::PH_ATTACK) begin
            nx = live_tab[i][f.link[1:0]];
            w = (f.attack != 0) ? (32'(f.count) * 256) / f.attack : 256;
            if (w > 256) w = 256;
            o.red   = 8'((f.red * w + nx.red * (256 - w)) >> 8);
            o.green = 8'((f.green * w + nx.green * (256 - w)) >> 8);
            o.blue  = 8'((f.blue * w + nx.blue * (256 - w)) >> 8);
            f.count = f.count + 1;
            if (f.count >= f.attack) begin
               f.phase = (f.hold != 0) ? lka_pkg::PH_HOLD : lka_pkg::PH_ATTACK;
               adv = 1'b1;
            end
         end else begin
            o.red = f.red;
            o.green = f.green;
            o.blue = f.blue;
            if (f.phase == lka_pkg::PH_HOLD) begin
               f.count = f.count + 1;
               if (f.count >= f.hold) begin
                  f.phase = (f.attack != 0) ? lka_pkg::PH_ATTACK : lka_pkg::PH_HOLD;
                  adv = 1'b1;
               end
            end
         end
         if (adv) f.count = '0;
         live_tab[i][play_slot[i]] = f;
         if (adv) play_slot[i] = f.link[1:0];
         o.led  = 2'(i);
         o.last = (i == 3);
         color_queue.push_back(o);
      end
   endtask

   // Predict on accepted items and compare accepted results.
   always @(posedge clock) begin
      led_color_type e;
      if (reset) begin
         for (int l = 0; l < 4; l++) begin
            play_slot[l] = '0;
            for (int s = 0; s < 4; s++) begin
               live_tab[l][s] = '0;
               stage_tab[l][s] = '0;
            end
         end
         color_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (color_queue.size() == 0) begin
               $error("unexpected color result for led %0d", rsp_led_index);
               fail_count++;
            end else begin
               e = color_queue.pop_front();
               if (rsp_led_index !== e.led) begin
                  $error("led_index expected %0d actual %0d", e.led, rsp_led_index);
                  fail_count++;
               end
               if (rsp_red !== e.red) begin
                  $error("red expected %0d actual %0d", e.red, rsp_red);
                  fail_count++;
               end
               if (rsp_green !== e.green) begin
                  $error("green expected %0d actual %0d", e.green, rsp_green);
                  fail_count++;
               end
               if (rsp_blue !== e.blue) begin
                  $error("blue expected %0d actual %0d", e.blue, rsp_blue);
                  fail_count++;
               end
               if (rsp_last_of_tick !== e.last) begin
                  $error("last_of_tick expected %0d actual %0d", e.last,
                         rsp_last_of_tick);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_mode) begin
               stage_keyframe(req_led_select, req_frame_slot, req_color_565,
                              req_attack_ticks, req_hold_ticks, req_last_frame);
               if (req_commit) begin
                  live_tab = stage_tab;
                  for (int l = 0; l < 4; l++) play_slot[l] = '0;
               end
            end else begin
               animate_tick();
            end
         end
      end
      pending_colors = color_queue.size();
   end
endmodule

// ----- tb/sv/led_keyframe_animator_top_tb.sv -----
// Testbench top for the LED keyframe animator: stimulus, idling and verdict.
module led_keyframe_animator_top_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [1:0]  req_led_select = '0;
   logic [1:0]  req_frame_slot = '0;
   logic [15:0] req_color_565 = '0;
   logic [7:0]  req_attack_ticks = '0;
   logic [7:0]  req_hold_ticks = '0;
   logic        req_last_frame = 1'b0;
   logic        req_commit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_led_index;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   logic        rsp_last_of_tick;
   int          fail_count;
   int          pending_colors;
   int          send_idle_pct = 27;
   int          recv_idle_pct = 54;
   bit          hold_off = 1'b0;
   int          quiet_cycles = 0;
   int          sent = 0;
   localparam int QUIET_LIMIT = 20000;

   led_keyframe_animator_top uut (.*);
   led_keyframe_animator_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random back-pressure, or a long hold-off when asked.
   always @(negedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // Long receiver hold-off once the run is under way, so the block fills up.
   initial begin
      wait (sent >= 230);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   // Watchdog on cycles with no handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one item and wait until it is accepted; valid stays up for the next one.
   task automatic send_item(input bit mode, input logic [1:0] led, input logic [1:0] slot,
                            input logic [15:0] c, input logic [7:0] att,
                            input logic [7:0] hld, input bit last, input bit cmt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_led_select <= led;
      req_frame_slot <= slot;
      req_color_565 <= c;
      req_attack_ticks <= att;
      req_hold_ticks <= hld;
      req_last_frame <= last;
      req_commit <= cmt;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(1'b0, 2'($urandom), 2'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Random keyframe, mostly short counts so the rings actually cycle.
   task automatic send_random_frame(input logic [1:0] led, input logic [1:0] slot,
                                    input bit last, input bit cmt);
      logic [7:0] att, hld;
      att = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      hld = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      send_item(1'b1, led, slot, 16'($urandom), att, hld, last, cmt);
   endtask

   initial begin
      int ring;
      int wait_cycles;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: ticks on cleared tables, color and count extremes, ring links.
      send_tick();
      send_item(1'b1, 2'd0, 2'd0, 16'hFFFF, 8'd0, 8'd0, 1'b1, 1'b0);
      send_item(1'b1, 2'd1, 2'd0, 16'hF800, 8'd2, 8'd1, 1'b0, 1'b0);
      send_item(1'b1, 2'd1, 2'd1, 16'h07E0, 8'd0, 8'd2, 1'b0, 1'b0);
      send_item(1'b1, 2'd1, 2'd2, 16'h001F, 8'd3, 8'd0, 1'b0, 1'b0);
      send_item(1'b1, 2'd1, 2'd3, 16'h0000, 8'd1, 8'd1, 1'b0, 1'b0);
      send_item(1'b1, 2'd2, 2'd0, 16'hAAAA, 8'd255, 8'd255, 1'b0, 1'b0);
      send_item(1'b1, 2'd2, 2'd1, 16'h5555, 8'd1, 8'd0, 1'b1, 1'b0);
      send_item(1'b1, 2'd3, 2'd0, 16'h1234, 8'd0, 8'd1, 1'b1, 1'b1);
      repeat (14) send_tick();
      send_item(1'b1, 2'd3, 2'd0, 16'hFFFF, 8'd2, 8'd0, 1'b0, 1'b1);
      repeat (4) send_tick();
      sent = 28;

      // Random: mostly rings written then committed, ticked many times.
      while (sent < 460) begin
         if (sent > 160 && send_idle_pct == 27) begin
            send_idle_pct = 54;
            recv_idle_pct = 27;
         end else if (sent > 310 && send_idle_pct == 54) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(9) < 2) begin
            send_random_frame(2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end else begin
            ring = $urandom_range(4);
            for (int k = 0; k < ring; k++) begin
               send_random_frame(2'($urandom), 2'(k), k == ring - 1, 1'b0);
               sent++;
            end
            send_random_frame(2'($urandom), 2'($urandom), 1'($urandom), 1'b1);
            sent++;
            for (int k = $urandom_range(12, 3); k > 0; k--) begin
               send_tick();
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      // Drain with a bounded wait, then allow for the block's latency.
      wait_cycles = 0;
      while (pending_colors != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_colors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
